@@ sv/fjr_pkg.sv @@
// shared constants, codes and types of the feeder jam-recovery block
`default_nettype none

package fjr_pkg;

	// angle format and tick counter width
	localparam int ANGLE_FRACTION_BITS = 16;
	localparam int COUNTER_WIDTH       = 16;

	// compare width for counters against 16-bit limits
	localparam int CMP_W = (COUNTER_WIDTH > 16) ? COUNTER_WIDTH : 16;

	// configuration port
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 20;

	localparam logic [CFG_INDEX_W-1:0] CFG_TORQUE_THRESHOLD = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_SUSPECT_TICKS    = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_RECOVER_TICKS    = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_STUCK_TICKS      = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_REST_TICKS       = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] CFG_BACKOFF_STEP     = 3'd5;

	// jam states
	localparam logic [2:0] ST_NORMAL  = 3'd0;
	localparam logic [2:0] ST_SUSPECT = 3'd1;
	localparam logic [2:0] ST_REACT   = 3'd2;
	localparam logic [2:0] ST_BACKOFF = 3'd3;
	localparam logic [2:0] ST_OPEN    = 3'd4;

	// drive mode commands
	localparam logic [1:0] DRIVE_KEEP  = 2'd0;
	localparam logic [1:0] DRIVE_ANGLE = 2'd1;
	localparam logic [1:0] DRIVE_OPEN  = 2'd2;

	// 2*pi/27 with 32 fraction bits, rounded to the angle format
	localparam logic [63:0] STEP_Q32 = 64'd999484274;
	localparam logic [19:0] BACKOFF_STEP_RESET = 20'(
		(STEP_Q32 + (64'd1 << (31 - ANGLE_FRACTION_BITS))) >> (32 - ANGLE_FRACTION_BITS));

	localparam logic [14:0] TORQUE_THRESHOLD_RESET = 15'd5000;
	localparam logic [15:0] SUSPECT_TICKS_RESET    = 16'd100;
	localparam logic [15:0] RECOVER_TICKS_RESET    = 16'd200;
	localparam logic [15:0] STUCK_TICKS_RESET      = 16'd400;
	localparam logic [15:0] REST_TICKS_RESET       = 16'd1000;

	typedef struct packed {
		logic [14:0] torque_threshold;
		logic [15:0] suspect_ticks;
		logic [15:0] recover_ticks;
		logic [15:0] stuck_ticks;
		logic [15:0] rest_ticks;
		logic [19:0] backoff_step;
	} cfg_t;

	typedef struct packed {
		logic [2:0]               jam_state;
		logic [COUNTER_WIDTH-1:0] state_ticks;
		logic [COUNTER_WIDTH-1:0] clear_run;
		logic [COUNTER_WIDTH-1:0] stuck_run;
		logic [COUNTER_WIDTH-1:0] rest_run;
	} state_t;

	typedef struct packed {
		logic [2:0]         jam_state;
		logic               run_feed_control;
		logic [1:0]         drive_mode;
		logic               target_valid;
		logic signed [31:0] target_angle;
		logic               clear_fire_timer;
	} result_t;

endpackage

`default_nettype wire

@@ sv/fjr_in_if.sv @@
// input channel: one control tick word per handshake
`default_nettype none

interface fjr_in_if;
	logic               valid;
	logic               ready;
	logic signed [14:0] motor_torque;
	logic signed [31:0] motor_angle;

	modport source (output valid, output motor_torque, output motor_angle, input ready);
	modport sink (input valid, input motor_torque, input motor_angle, output ready);
endinterface

`default_nettype wire

@@ sv/fjr_out_if.sv @@
// result channel: one command word per handshake
`default_nettype none

interface fjr_out_if;
	logic               valid;
	logic               ready;
	logic [2:0]         jam_state;
	logic               run_feed_control;
	logic [1:0]         drive_mode;
	logic               target_valid;
	logic signed [31:0] target_angle;
	logic               clear_fire_timer;

	modport source (output valid, output jam_state, output run_feed_control,
		output drive_mode, output target_valid, output target_angle,
		output clear_fire_timer, input ready);
	modport sink (input valid, input jam_state, input run_feed_control,
		input drive_mode, input target_valid, input target_angle,
		input clear_fire_timer, output ready);
endinterface

`default_nettype wire

@@ sv/fjr_cfg_regs.sv @@
// configuration register file of the jam-recovery block
`default_nettype none

module fjr_cfg_regs (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               we,
	input  wire logic [fjr_pkg::CFG_INDEX_W-1:0]    index,
	input  wire logic [fjr_pkg::CFG_DATA_W-1:0]     data,
	output fjr_pkg::cfg_t                           cfg
);

	fjr_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.torque_threshold <= fjr_pkg::TORQUE_THRESHOLD_RESET;
			cfg_q.suspect_ticks    <= fjr_pkg::SUSPECT_TICKS_RESET;
			cfg_q.recover_ticks    <= fjr_pkg::RECOVER_TICKS_RESET;
			cfg_q.stuck_ticks      <= fjr_pkg::STUCK_TICKS_RESET;
			cfg_q.rest_ticks       <= fjr_pkg::REST_TICKS_RESET;
			cfg_q.backoff_step     <= fjr_pkg::BACKOFF_STEP_RESET;
		end else if (we) begin
			case (index)
				fjr_pkg::CFG_TORQUE_THRESHOLD: cfg_q.torque_threshold <= data[14:0];
				fjr_pkg::CFG_SUSPECT_TICKS:    cfg_q.suspect_ticks    <= data[15:0];
				fjr_pkg::CFG_RECOVER_TICKS:    cfg_q.recover_ticks    <= data[15:0];
				fjr_pkg::CFG_STUCK_TICKS:      cfg_q.stuck_ticks      <= data[15:0];
				fjr_pkg::CFG_REST_TICKS:       cfg_q.rest_ticks       <= data[15:0];
				fjr_pkg::CFG_BACKOFF_STEP:     cfg_q.backoff_step     <= data[19:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

@@ sv/fjr_step.sv @@
// next-state and command logic for one control tick
`default_nettype none

module fjr_step (
	input  wire fjr_pkg::state_t     cur,
	input  wire fjr_pkg::cfg_t       cfg,
	input  wire logic signed [14:0]  motor_torque,
	input  wire logic signed [31:0]  motor_angle,
	output fjr_pkg::state_t          nxt,
	output fjr_pkg::result_t         res
);

	localparam int CW = fjr_pkg::COUNTER_WIDTH;

	function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
		return (&v) ? v : v + 1'b1;
	endfunction

	function automatic logic at_least(input logic [CW-1:0] cnt, input logic [15:0] lim);
		return fjr_pkg::CMP_W'(cnt) >= fjr_pkg::CMP_W'(lim);
	endfunction

	function automatic logic above(input logic [CW-1:0] cnt, input logic [15:0] lim);
		return fjr_pkg::CMP_W'(cnt) > fjr_pkg::CMP_W'(lim);
	endfunction

	always_comb begin
		logic [14:0]   traw;
		logic [15:0]   mag;
		logic          loaded;
		logic [CW-1:0] clear_n;
		logic [CW-1:0] stuck_n;
		logic [CW-1:0] rest_n;

		// torque magnitude, most negative code gives 16384
		traw   = motor_torque;
		mag    = traw[14] ? (16'h8000 - {1'b0, traw}) : {1'b0, traw};
		loaded = mag >= {1'b0, cfg.torque_threshold};

		nxt             = cur;
		nxt.state_ticks = sat_inc(cur.state_ticks);

		res.jam_state        = cur.jam_state;
		res.run_feed_control = 1'b0;
		res.drive_mode       = fjr_pkg::DRIVE_KEEP;
		res.target_valid     = 1'b0;
		res.target_angle     = '0;
		res.clear_fire_timer = 1'b0;

		clear_n = '0;
		stuck_n = '0;
		rest_n  = '0;

		case (cur.jam_state)
			fjr_pkg::ST_SUSPECT: begin
				res.run_feed_control = 1'b1;
				if (at_least(nxt.state_ticks, cfg.suspect_ticks)) begin
					nxt.jam_state   = fjr_pkg::ST_REACT;
					nxt.state_ticks = '0;
				end else if (!loaded) begin
					nxt.jam_state   = fjr_pkg::ST_NORMAL;
					nxt.state_ticks = '0;
				end
			end
			fjr_pkg::ST_REACT: begin
				res.clear_fire_timer = 1'b1;
				res.drive_mode       = fjr_pkg::DRIVE_ANGLE;
				res.target_valid     = 1'b1;
				res.target_angle     = motor_angle - $signed({12'd0, cfg.backoff_step});
				nxt.jam_state        = fjr_pkg::ST_BACKOFF;
				nxt.state_ticks      = '0;
			end
			fjr_pkg::ST_BACKOFF: begin
				clear_n = loaded ? '0 : sat_inc(cur.clear_run);
				stuck_n = loaded ? sat_inc(cur.stuck_run) : '0;
				nxt.clear_run = clear_n;
				nxt.stuck_run = stuck_n;
				if (at_least(clear_n, cfg.recover_ticks)) begin
					nxt.clear_run   = '0;
					nxt.jam_state   = fjr_pkg::ST_NORMAL;
					nxt.state_ticks = '0;
				end
				// stuck check comes second and wins when both fire
				if (at_least(stuck_n, cfg.stuck_ticks)) begin
					nxt.stuck_run   = '0;
					nxt.jam_state   = fjr_pkg::ST_OPEN;
					nxt.state_ticks = '0;
				end
			end
			fjr_pkg::ST_OPEN: begin
				res.run_feed_control = 1'b1;
				res.drive_mode       = fjr_pkg::DRIVE_OPEN;
				rest_n               = sat_inc(cur.rest_run);
				nxt.rest_run         = rest_n;
				if (above(rest_n, cfg.rest_ticks) && !loaded) begin
					res.target_valid = 1'b1;
					res.target_angle = motor_angle;
					nxt.rest_run     = '0;
					nxt.jam_state    = fjr_pkg::ST_SUSPECT;
					nxt.state_ticks  = '0;
				end
			end
			default: begin
				// normal, and unused codes behave as normal
				res.jam_state        = fjr_pkg::ST_NORMAL;
				res.run_feed_control = 1'b1;
				if (loaded) begin
					nxt.jam_state   = fjr_pkg::ST_SUSPECT;
					nxt.state_ticks = '0;
				end
			end
		endcase
	end

endmodule

`default_nettype wire

@@ sv/feeder_jam_recovery_fsm.sv @@
// top level of the feeder jam-recovery state machine
//
// feed_in carries one control tick per word: signed torque current and the
// output angle in fixed point; result_out carries one command word per tick
// (jam state, feed-control enable, drive mode, optional angle target and a
// fire-timer clear). both channels are valid/ready, a word moves when both are
// high. a tick word is first captured in an input register; from there one
// pass of compare-and-count logic updates the state and loads the result
// register, from which the result word is offered to result_out.
// throughput is one word per cycle: the input register refills in the same
// cycle its word moves on, and it only holds when the result register is full
// and the receiver is stalling, which is when feed_in ready drops.
// reset (arst_n low) empties both registers, puts the machine in normal with
// all tick counters at zero and loads the default configuration.
// cfg_we/cfg_index/cfg_data write one configuration register per cycle; write
// only while no tick is in flight.
`default_nettype none

module feeder_jam_recovery_fsm (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	fjr_in_if.sink                                  feed_in,
	fjr_out_if.source                               result_out,
	input  wire logic                               cfg_we,
	input  wire logic [fjr_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  wire logic [fjr_pkg::CFG_DATA_W-1:0]     cfg_data
);

	fjr_pkg::cfg_t    cfg;
	fjr_pkg::state_t  state_q;
	fjr_pkg::state_t  state_nxt;
	fjr_pkg::result_t res_nxt;
	fjr_pkg::result_t result_q;

	// input register
	logic               in_valid_s1;
	logic signed [14:0] torque_s1;
	logic signed [31:0] angle_s1;

	logic out_valid_q;
	logic advance;
	logic take_in;

	// the tick in the input register moves on when the result slot is free
	assign advance = in_valid_s1 && (!out_valid_q || result_out.ready);
	assign feed_in.ready = !in_valid_s1 || advance;
	assign take_in = feed_in.valid && feed_in.ready;

	fjr_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	fjr_step u_step (
		.cur          (state_q),
		.cfg          (cfg),
		.motor_torque (torque_s1),
		.motor_angle  (angle_s1),
		.nxt          (state_nxt),
		.res          (res_nxt)
	);

	// input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (feed_in.ready) begin
			in_valid_s1 <= feed_in.valid;
		end
	end

	// input payload, no reset needed
	always_ff @(posedge clk) begin
		if (take_in) begin
			torque_s1 <= feed_in.motor_torque;
			angle_s1  <= feed_in.motor_angle;
		end
	end

	// machine state moves exactly once per tick, when its result is loaded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.jam_state   <= fjr_pkg::ST_NORMAL;
			state_q.state_ticks <= '0;
			state_q.clear_run   <= '0;
			state_q.stuck_run   <= '0;
			state_q.rest_run    <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= res_nxt;
		end
	end

	assign result_out.valid            = out_valid_q;
	assign result_out.jam_state        = result_q.jam_state;
	assign result_out.run_feed_control = result_q.run_feed_control;
	assign result_out.drive_mode       = result_q.drive_mode;
	assign result_out.target_valid     = result_q.target_valid;
	assign result_out.target_angle     = result_q.target_angle;
	assign result_out.clear_fire_timer = result_q.clear_fire_timer;

	// react always hands over to back-off on the next tick
	a_react_to_backoff: assert property (@(posedge clk) disable iff (!arst_n)
		advance && state_q.jam_state == fjr_pkg::ST_REACT
		|=> state_q.jam_state == fjr_pkg::ST_BACKOFF && state_q.state_ticks == '0)
		else $error("react did not lead to back-off");

	// angle mode command comes with a target and a fire-timer clear
	a_angle_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && result_q.drive_mode == fjr_pkg::DRIVE_ANGLE
		|-> result_q.target_valid && result_q.clear_fire_timer
			&& result_q.jam_state == fjr_pkg::ST_REACT)
		else $error("angle mode word without target or timer clear");

	// feed control is held off during react and back-off
	a_feed_off: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (result_q.jam_state == fjr_pkg::ST_REACT
			|| result_q.jam_state == fjr_pkg::ST_BACKOFF)
		|-> !result_q.run_feed_control)
		else $error("feed control enabled during recovery");

	// a held tick word is not overwritten while the result slot is blocked
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid_s1 && !advance |=> in_valid_s1 && $stable(angle_s1) && $stable(torque_s1))
		else $error("held tick word changed");

endmodule

`default_nettype wire
